/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define STT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/stt_pkg.sv */
`timescale 1ns / 1ps
package stt_pkg;

  localparam int POS_WIDTH_DEF = 16;

  // input operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // result kinds
  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR = 2'd2;

  // token kinds
  localparam logic [5:0] TK_END    = 6'd0;
  localparam logic [5:0] TK_IDENT  = 6'd1;
  localparam logic [5:0] TK_NUMBER = 6'd2;
  localparam logic [5:0] TK_STRING = 6'd3;
  localparam logic [5:0] TK_KW_SA  = 6'd17;
  localparam logic [5:0] TK_NONE   = 6'd0;

  // special characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDENT,
    ST_INT,
    ST_FRAC,
    ST_STRING,
    ST_COMMENT,
    ST_OPER
  } mode_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } rslt_t;

  // all results caused by one input item
  typedef struct packed {
    logic [1:0]      cnt;
    rslt_t [2:0]     res;
  } bndl_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c == CH_UNDER) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // single-character operator code, zero if none
  function automatic logic [5:0] single_op_code(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h2B:   r = 6'd18;  // +
      8'h2D:   r = 6'd19;  // -
      8'h2A:   r = 6'd20;  // *
      8'h2F:   r = 6'd21;  // /
      8'h5E:   r = 6'd22;  // ^
      8'h40:   r = 6'd23;  // @
      8'h2C:   r = 6'd24;  // ,
      8'h3B:   r = 6'd25;  // ;
      8'h28:   r = 6'd26;  // (
      8'h29:   r = 6'd27;  // )
      8'h7B:   r = 6'd28;  // {
      8'h7D:   r = 6'd29;  // }
      8'h5B:   r = 6'd30;  // [
      8'h5D:   r = 6'd31;  // ]
      8'h21:   r = 6'd32;  // !
      8'h3D:   r = 6'd34;  // =
      8'h3E:   r = 6'd36;  // >
      8'h3C:   r = 6'd38;  // <
      default: r = TK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] keyword_code(input logic [7:0] a, input logic [7:0] b,
                                              input logic len1, input logic len2);
    logic [5:0] r;
    r = TK_IDENT;
    if (len2) begin
      if ((a == 8'h73) && (b == 8'h61)) r = TK_KW_SA;
    end else if (len1) begin
      case (a)
        8'h41:   r = 6'd4;   // A
        8'h4F:   r = 6'd5;   // O
        8'h54:   r = 6'd6;   // T
        8'h46:   r = 6'd7;   // F
        8'h66:   r = 6'd8;   // f
        8'h6F:   r = 6'd9;   // o
        8'h4E:   r = 6'd10;  // N
        8'h69:   r = 6'd11;  // i
        8'h70:   r = 6'd12;  // p
        8'h72:   r = 6'd13;  // r
        8'h61:   r = 6'd14;  // a
        8'h77:   r = 6'd15;  // w
        8'h73:   r = 6'd16;  // s
        default: r = TK_IDENT;
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/stt_in_if.sv */
`timescale 1ns / 1ps
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_code;

  modport source (output valid, output op, output char_code, input ready);
  modport sink (input valid, input op, input char_code, output ready);
endinterface

/* rtl/stt_out_if.sv */
`timescale 1ns / 1ps
interface stt_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  token_kind;
  logic [1:0]  error_code;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output kind, output token_kind, output error_code,
                  output start_line, output start_column, output token_length,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input token_kind, input error_code,
                input start_line, input start_column, input token_length,
                input last_of_run, output ready);
endinterface

/* rtl/stt_step.sv */
`timescale 1ns / 1ps
module stt_step #(
  parameter int POS_WIDTH = stt_pkg::POS_WIDTH_DEF
) (
  input  logic                 op,
  input  logic [7:0]           ch,
  input  stt_pkg::mode_t       mode_q,
  input  logic [POS_WIDTH-1:0] line_q,
  input  logic [POS_WIDTH-1:0] col_q,
  input  logic [POS_WIDTH-1:0] tsl_q,
  input  logic [POS_WIDTH-1:0] tsc_q,
  input  logic [POS_WIDTH-1:0] tcc_q,
  input  logic [15:0]          ftc_q,
  output stt_pkg::mode_t       mode_nxt,
  output logic [POS_WIDTH-1:0] line_nxt,
  output logic [POS_WIDTH-1:0] col_nxt,
  output logic [POS_WIDTH-1:0] tsl_nxt,
  output logic [POS_WIDTH-1:0] tsc_nxt,
  output logic [POS_WIDTH-1:0] tcc_nxt,
  output logic [15:0]          ftc_nxt,
  output stt_pkg::bndl_t       bnd
);
  import stt_pkg::*;

  localparam logic [POS_WIDTH-1:0] PosMax = '1;
  localparam logic [POS_WIDTH-1:0] PosOne = POS_WIDTH'(1);

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

  logic [5:0]           op1_in;
  logic [5:0]           op1_pend;
  logic [5:0]           kw;
  logic                 tok_v;
  logic [5:0]           tok_kind;
  logic [POS_WIDTH-1:0] tok_len;
  logic                 err2_v;
  logic                 sc;
  logic                 sc_err;
  logic                 end_v;
  logic                 pend_cmp;
  rslt_t                cand [4];
  logic [3:0]           cvld;
  logic [1:0]           idx;

  assign op1_in   = single_op_code(ch);
  assign op1_pend = single_op_code(ftc_q[7:0]);
  assign kw       = keyword_code(ftc_q[7:0], ftc_q[15:8], tcc_q == PosOne,
                                 tcc_q == POS_WIDTH'(2));
  assign pend_cmp = (ftc_q[7:0] == CH_BANG) || (ftc_q[7:0] == CH_EQ) ||
                    (ftc_q[7:0] == CH_GT) || (ftc_q[7:0] == CH_LT);

  always_comb begin
    mode_nxt = mode_q;
    line_nxt = line_q;
    col_nxt  = col_q;
    tsl_nxt  = tsl_q;
    tsc_nxt  = tsc_q;
    tcc_nxt  = tcc_q;
    ftc_nxt  = ftc_q;
    tok_v    = 1'b0;
    tok_kind = TK_NONE;
    tok_len  = tcc_q;
    err2_v   = 1'b0;
    sc       = 1'b0;
    sc_err   = 1'b0;
    end_v    = 1'b0;

    if (op == OP_END) begin
      case (mode_q)
        ST_IDENT: begin
          tok_v    = 1'b1;
          tok_kind = kw;
        end
        ST_INT, ST_FRAC: begin
          tok_v    = 1'b1;
          tok_kind = TK_NUMBER;
        end
        ST_OPER: begin
          tok_v    = 1'b1;
          tok_kind = op1_pend;
        end
        ST_STRING: begin
          err2_v   = 1'b1;
          tok_v    = 1'b1;
          tok_kind = TK_STRING;
        end
        default: ;
      endcase
      end_v    = 1'b1;
      mode_nxt = ST_IDLE;
      line_nxt = '0;
      col_nxt  = '0;
      tsl_nxt  = '0;
      tsc_nxt  = '0;
      tcc_nxt  = '0;
      ftc_nxt  = '0;
    end else begin
      case (mode_q)
        ST_IDENT: begin
          if (is_letter(ch)) begin
            if (tcc_q == PosOne) ftc_nxt[15:8] = ch;
            tcc_nxt = sat_inc(tcc_q);
            col_nxt = sat_inc(col_q);
          end else begin
            tok_v    = 1'b1;
            tok_kind = kw;
            sc       = 1'b1;
          end
        end
        ST_INT, ST_FRAC: begin
          if (is_dig(ch) || ((mode_q == ST_INT) && (ch == CH_DOT))) begin
            tcc_nxt = sat_inc(tcc_q);
            col_nxt = sat_inc(col_q);
            if (ch == CH_DOT) mode_nxt = ST_FRAC;
          end else begin
            tok_v    = 1'b1;
            tok_kind = TK_NUMBER;
            sc       = 1'b1;
          end
        end
        ST_STRING: begin
          if (ch == CH_QUOTE) begin
            tcc_nxt  = sat_inc(tcc_q);
            col_nxt  = sat_inc(col_q);
            tok_v    = 1'b1;
            tok_kind = TK_STRING;
            tok_len  = sat_inc(tcc_q);
            mode_nxt = ST_IDLE;
          end else if (ch == CH_NL) begin
            err2_v   = 1'b1;
            tok_v    = 1'b1;
            tok_kind = TK_STRING;
            line_nxt = sat_inc(line_q);
            col_nxt  = '0;
            mode_nxt = ST_IDLE;
          end else begin
            tcc_nxt = sat_inc(tcc_q);
            col_nxt = sat_inc(col_q);
          end
        end
        ST_COMMENT: begin
          if (ch == CH_NL) begin
            line_nxt = sat_inc(line_q);
            col_nxt  = '0;
            mode_nxt = ST_IDLE;
          end else begin
            col_nxt = sat_inc(col_q);
          end
        end
        ST_OPER: begin
          if ((ch == CH_EQ) && pend_cmp) begin
            tcc_nxt  = sat_inc(tcc_q);
            col_nxt  = sat_inc(col_q);
            tok_v    = 1'b1;
            tok_kind = op1_pend + 6'd1;
            tok_len  = sat_inc(tcc_q);
            mode_nxt = ST_IDLE;
          end else begin
            tok_v    = 1'b1;
            tok_kind = op1_pend;
            sc       = 1'b1;
          end
        end
        default: sc = 1'b1;
      endcase

      // handle this byte afresh: start a lexeme or comment, take a newline or blank, or flag a bad byte
      if (sc) begin
        mode_nxt = ST_IDLE;
        col_nxt  = sat_inc(col_q);
        if ((op1_in != TK_NONE) || (ch == CH_QUOTE) || is_dig(ch) || is_letter(ch)) begin
          tsl_nxt = line_q;
          tsc_nxt = col_q;
          tcc_nxt = PosOne;
          ftc_nxt = {8'h00, ch};
          if (op1_in != TK_NONE) mode_nxt = ST_OPER;
          else if (ch == CH_QUOTE) mode_nxt = ST_STRING;
          else if (is_dig(ch)) mode_nxt = ST_INT;
          else mode_nxt = ST_IDENT;
        end else if (ch == CH_HASH) begin
          mode_nxt = ST_COMMENT;
        end else if (ch == CH_NL) begin
          line_nxt = sat_inc(line_q);
          col_nxt  = '0;
        end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR)) begin
          mode_nxt = ST_IDLE;
        end else begin
          sc_err = 1'b1;
        end
      end
    end
  end

  // candidates in emission order: open string error, token, bad byte, end
  always_comb begin
    cand[0] = '{kind: KIND_ERROR, token_kind: TK_NONE, error_code: ERR_OPEN_STR,
                start_line: 16'(line_q), start_column: 16'(col_q), token_length: 16'd0,
                last_of_run: 1'b0};
    cand[1] = '{kind: KIND_TOKEN, token_kind: tok_kind, error_code: ERR_NONE,
                start_line: 16'(tsl_q), start_column: 16'(tsc_q),
                token_length: 16'(tok_len), last_of_run: 1'b0};
    cand[2] = '{kind: KIND_ERROR, token_kind: TK_NONE, error_code: ERR_BAD_CHAR,
                start_line: 16'(line_q), start_column: 16'(col_q), token_length: 16'd0,
                last_of_run: 1'b0};
    cand[3] = '{kind: KIND_TOKEN, token_kind: TK_END, error_code: ERR_NONE,
                start_line: 16'(line_q), start_column: 16'(col_q), token_length: 16'd0,
                last_of_run: 1'b0};
    cvld = {end_v, sc_err, tok_v, err2_v};
  end

  // pack present results into consecutive slots
  always_comb begin
    bnd = '0;
    idx = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cvld[i] && (idx != 2'd3)) begin
        bnd.res[idx] = cand[i];
        idx = idx + 2'd1;
      end
    end
    bnd.cnt = idx;
    if (idx != 2'd0) bnd.res[idx - 2'd1].last_of_run = 1'b1;
  end

endmodule

/* rtl/source_text_tokenizer.sv */
`timescale 1ns / 1ps
// Streaming lexer: source bytes (op 0) and an end-of-input marker (op 1) enter
// on in_ch; tokens and error reports leave on out_ch, one result per beat, with
// last_of_run set on the final result that an input beat caused. An input beat
// is classified in the cycle it is accepted and its results (zero to three)
// land together in a two-entry result buffer, so the block takes one byte per
// cycle while in_ch.ready is high; results leave from the buffer. Throughput
// is set by the output port: an item with n results holds the output for n
// beats, and in_ch.ready drops only when both buffer entries are occupied and
// the older one is not finishing its last beat. Positions and lengths count in
// POS_WIDTH bits, saturate at the top value, and are reported in 16 bits.
// A token is reported on the beat that ends it; end of input flushes any open
// token, emits END and restarts at line 0, column 0.
module source_text_tokenizer #(
  parameter int POS_WIDTH = stt_pkg::POS_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  stt_in_if.sink      in_ch,
  stt_out_if.source   out_ch
);
  import stt_pkg::*;
  `include "assert_macros.svh"

  // scanner state
  mode_t                mode_r;
  logic [POS_WIDTH-1:0] line_r;
  logic [POS_WIDTH-1:0] col_r;
  logic [POS_WIDTH-1:0] tsl_r;
  logic [POS_WIDTH-1:0] tsc_r;
  logic [POS_WIDTH-1:0] tcc_r;
  logic [15:0]          ftc_r;

  mode_t                mode_nxt;
  logic [POS_WIDTH-1:0] line_nxt;
  logic [POS_WIDTH-1:0] col_nxt;
  logic [POS_WIDTH-1:0] tsl_nxt;
  logic [POS_WIDTH-1:0] tsc_nxt;
  logic [POS_WIDTH-1:0] tcc_nxt;
  logic [15:0]          ftc_nxt;
  bndl_t                bnd;

  // result buffer: two bundles, drained one slot per beat
  bndl_t      bnd_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] fill_r;
  logic [1:0] sub_r;

  bndl_t      cur;
  rslt_t      cur_res;
  logic       in_acc;
  logic       out_beat;
  logic       push;
  logic       pop;
  logic       last_slot;

  stt_step #(.POS_WIDTH(POS_WIDTH)) u_step (
    .op       (in_ch.op),
    .ch       (in_ch.char_code),
    .mode_q   (mode_r),
    .line_q   (line_r),
    .col_q    (col_r),
    .tsl_q    (tsl_r),
    .tsc_q    (tsc_r),
    .tcc_q    (tcc_r),
    .ftc_q    (ftc_r),
    .mode_nxt (mode_nxt),
    .line_nxt (line_nxt),
    .col_nxt  (col_nxt),
    .tsl_nxt  (tsl_nxt),
    .tsc_nxt  (tsc_nxt),
    .tcc_nxt  (tcc_nxt),
    .ftc_nxt  (ftc_nxt),
    .bnd      (bnd)
  );

  assign cur       = bnd_r[rd_r];
  assign cur_res   = cur.res[sub_r];
  assign last_slot = (sub_r == (cur.cnt - 2'd1));

  assign out_ch.valid        = (fill_r != 2'd0);
  assign out_ch.kind         = cur_res.kind;
  assign out_ch.token_kind   = cur_res.token_kind;
  assign out_ch.error_code   = cur_res.error_code;
  assign out_ch.start_line   = cur_res.start_line;
  assign out_ch.start_column = cur_res.start_column;
  assign out_ch.token_length = cur_res.token_length;
  assign out_ch.last_of_run  = cur_res.last_of_run;

  assign out_beat = out_ch.valid && out_ch.ready;
  assign pop      = out_beat && last_slot;

  // take a new beat whenever a buffer entry is free or frees up now
  assign in_ch.ready = (fill_r != 2'd2) || pop;
  assign in_acc      = in_ch.valid && in_ch.ready;
  // beats that cause no result never enter the buffer
  assign push        = in_acc && (bnd.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ST_IDLE;
      line_r <= '0;
      col_r  <= '0;
      tsl_r  <= '0;
      tsc_r  <= '0;
      tcc_r  <= '0;
      ftc_r  <= '0;
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
      sub_r  <= 2'd0;
    end else begin
      if (in_acc) begin
        mode_r <= mode_nxt;
        line_r <= line_nxt;
        col_r  <= col_nxt;
        tsl_r  <= tsl_nxt;
        tsc_r  <= tsc_nxt;
        tcc_r  <= tcc_nxt;
        ftc_r  <= ftc_nxt;
      end
      if (push) wr_r <= ~wr_r;
      // advance through the head bundle; drop it after its last slot
      if (out_beat) begin
        if (last_slot) begin
          sub_r <= 2'd0;
          rd_r  <= ~rd_r;
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold bundle payload, no reset needed
  always_ff @(posedge clk) begin
    if (push) bnd_r[wr_r] <= bnd;
  end

  `STT_ASSERT(a_slot_in_range, out_ch.valid |-> (sub_r < cur.cnt), "slot index past bundle")
  `STT_ASSERT(a_last_flag, out_ch.valid |-> (out_ch.last_of_run == last_slot), "last_of_run misplaced")
  `STT_ASSERT(a_end_restart, (in_acc && (in_ch.op == OP_END)) |=> ((mode_r == ST_IDLE) && (line_r == '0) && (col_r == '0)), "end of input did not restart scanner")
  `STT_ASSERT(a_fill_bound, fill_r != 2'd3, "result buffer overfilled")
  `STT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (fill_r == 2'd0), "buffer not empty after reset")

endmodule
